// ===== rtl/npf_pkg.sv =====
`timescale 1ns / 1ps
package npf_pkg;

	localparam int MAX_POINTS = 16;
	localparam int FRAC_BITS = 16;
	localparam int AW = $clog2(MAX_POINTS);
	localparam int CW = $clog2(MAX_POINTS + 1);
	localparam int POWER_W = 4;
	localparam int STATUS_W = 3;

	typedef logic [AW-1:0] addr_t;
	typedef logic [CW-1:0] cnt_t;
	typedef logic signed [31:0] q_t;

	localparam q_t Q_MAX = q_t'(32'h7fffffff);
	localparam q_t Q_MIN = q_t'(32'h80000000);
	localparam q_t Q_ONE = q_t'(64'd1 << FRAC_BITS);

	localparam logic [STATUS_W-1:0] ST_OK = 3'd0;
	localparam logic [STATUS_W-1:0] ST_EQUAL = 3'd1;
	localparam logic [STATUS_W-1:0] ST_FULL = 3'd2;
	localparam logic [STATUS_W-1:0] ST_SAT = 3'd3;
	localparam logic [STATUS_W-1:0] ST_NOFIT = 3'd4;

	localparam logic KIND_COEF = 1'b0;
	localparam logic KIND_VALUE = 1'b1;
	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_EVAL = 1'b1;

	localparam logic [1:0] OPA_X = 2'd0;
	localparam logic [1:0] OPA_ABS = 2'd1;
	localparam logic [1:0] OPA_DIF = 2'd2;
	localparam logic OPB_ACC = 1'b0;
	localparam logic OPB_BAS = 1'b1;
	localparam logic [1:0] ADD_COF = 2'd0;
	localparam logic [1:0] ADD_BAS = 2'd1;
	localparam logic [1:0] ADD_ZERO = 2'd2;
	localparam logic DWS_IN = 1'b0;
	localparam logic DWS_DIV = 1'b1;
	localparam logic [1:0] BWS_ZERO = 2'd0;
	localparam logic [1:0] BWS_ONE = 2'd1;
	localparam logic [1:0] BWS_MAC = 2'd2;
	localparam logic [1:0] CWS_ZERO = 2'd0;
	localparam logic [1:0] CWS_COPY = 2'd1;
	localparam logic [1:0] CWS_MAC = 2'd2;
	localparam logic [1:0] OUT_ZERO = 2'd0;
	localparam logic [1:0] OUT_ACC = 2'd1;
	localparam logic [1:0] OUT_COEF = 2'd2;

	typedef struct packed {
		addr_t abs_ra;
		addr_t abs_rb;
		addr_t dif_ra;
		addr_t dif_rb;
		addr_t bas_ra;
		addr_t bas_rb;
		addr_t cof_ra;
		addr_t cof_rb;
		addr_t wa;
		logic abs_we;
		logic dif_we;
		logic dif_wsel;
		logic bas_we;
		logic [1:0] bas_wsel;
		logic cof_we;
		logic [1:0] cof_wsel;
		logic [1:0] opa_sel;
		logic opb_sel;
		logic [1:0] add_sel;
		logic mac_sub;
		logic mac_commit;
		logic acc_load_coef;
		logic acc_load_mac;
		logic x_load;
		logic sat_clr;
		logic div_start;
		logic div_commit;
		logic out_load;
		logic [1:0] out_vsel;
		logic out_kind;
		logic [POWER_W-1:0] out_power;
		logic out_last;
		logic [STATUS_W-1:0] out_status;
	} cmd_t;

	typedef struct packed {
		logic den_zero;
		logic div_done;
		logic out_free;
		logic sat;
	} sts_t;

endpackage

// ===== rtl/npf_ram.sv =====
`timescale 1ns / 1ps
module npf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

// ===== rtl/npf_div.sv =====
`timescale 1ns / 1ps
module npf_div import npf_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [32:0] num,
	input  logic signed [32:0] den,
	output logic               done,
	output q_t                 quot,
	output logic               sat
);

	localparam int DW = 33 + FRAC_BITS;
	localparam int NW = $clog2(DW + 1);

	logic [DW-1:0] dvd_q;
	logic [32:0] dvs_q;
	logic [33:0] rem_q;
	logic [NW-1:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic neg_q;
	logic [32:0] num_mag;
	logic [32:0] den_mag;
	logic [33:0] rem_sh;
	logic [33:0] rem_sub;

	assign num_mag = num[32] ? 33'(-num) : 33'(num);
	assign den_mag = den[32] ? 33'(-den) : 33'(den);
	assign rem_sh = {rem_q[32:0], dvd_q[DW-1]};
	assign rem_sub = rem_sh - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= NW'(DW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == NW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= {num_mag, {FRAC_BITS{1'b0}}};
			dvs_q <= den_mag;
			rem_q <= '0;
			neg_q <= num[32] ^ den[32];
		end else if (busy_q) begin
			if (!rem_sub[33]) begin
				rem_q <= rem_sub;
				dvd_q <= {dvd_q[DW-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				dvd_q <= {dvd_q[DW-2:0], 1'b0};
			end
		end
	end

	always_comb begin
		sat = 1'b0;
		if (!neg_q && dvd_q > DW'(32'h7fffffff)) begin
			quot = Q_MAX;
			sat = 1'b1;
		end else if (neg_q && dvd_q > DW'(32'h80000000)) begin
			quot = Q_MIN;
			sat = 1'b1;
		end else if (neg_q) begin
			quot = -q_t'(dvd_q[31:0]);
		end else begin
			quot = q_t'(dvd_q[31:0]);
		end
	end

	assign done = done_q;

endmodule

// ===== rtl/npf_datapath.sv =====
`timescale 1ns / 1ps
module npf_datapath import npf_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  cmd_t                cmd,
	output sts_t                sts,
	input  q_t                  in_x,
	input  q_t                  in_f,
	input  logic                out_ready,
	output logic                out_valid,
	output logic                out_kind,
	output q_t                  out_value,
	output logic [POWER_W-1:0]  out_power,
	output logic                out_last,
	output logic [STATUS_W-1:0] out_status
);

	q_t abs_a, abs_b, dif_a, dif_b, bas_a, bas_b, cof_a, cof_b;
	q_t dif_wd, bas_wd, cof_wd;
	q_t x_q, acc_q, mq_q;
	q_t opa, opb, addend, mq_d, mac_res, div_quot;
	logic signed [63:0] p_s1;
	logic [63:0] pmag, prnd;
	logic pneg, mq_sat_d, mq_sat_q;
	logic signed [32:0] sum, num, den;
	logic add_sat, div_done, div_sat;
	logic sat_q;
	logic out_valid_q;

	npf_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_abs (
		.clk(clk), .we(cmd.abs_we), .waddr(cmd.wa), .wdata(in_x),
		.raddr_a(cmd.abs_ra), .raddr_b(cmd.abs_rb), .rdata_a(abs_a), .rdata_b(abs_b)
	);

	npf_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_dif (
		.clk(clk), .we(cmd.dif_we), .waddr(cmd.wa), .wdata(dif_wd),
		.raddr_a(cmd.dif_ra), .raddr_b(cmd.dif_rb), .rdata_a(dif_a), .rdata_b(dif_b)
	);

	npf_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_bas (
		.clk(clk), .we(cmd.bas_we), .waddr(cmd.wa), .wdata(bas_wd),
		.raddr_a(cmd.bas_ra), .raddr_b(cmd.bas_rb), .rdata_a(bas_a), .rdata_b(bas_b)
	);

	npf_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_cof (
		.clk(clk), .we(cmd.cof_we), .waddr(cmd.wa), .wdata(cof_wd),
		.raddr_a(cmd.cof_ra), .raddr_b(cmd.cof_rb), .rdata_a(cof_a), .rdata_b(cof_b)
	);

	assign num = 33'(dif_a) - 33'(dif_b);
	assign den = 33'(abs_a) - 33'(abs_b);

	npf_div u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start), .num(num), .den(den),
		.done(div_done), .quot(div_quot), .sat(div_sat)
	);

	always_comb begin
		case (cmd.opa_sel)
			OPA_ABS: opa = abs_a;
			OPA_DIF: opa = dif_a;
			default: opa = x_q;
		endcase
		opb = (cmd.opb_sel == OPB_BAS) ? bas_a : acc_q;
		case (cmd.add_sel)
			ADD_BAS: addend = bas_b;
			ADD_ZERO: addend = '0;
			default: addend = cof_a;
		endcase
	end

	always_ff @(posedge clk) begin
		p_s1 <= opa * opb;
		mq_q <= mq_d;
		mq_sat_q <= mq_sat_d;
	end

	always_comb begin
		pneg = p_s1[63];
		pmag = pneg ? 64'(-p_s1) : 64'(p_s1);
		prnd = (pmag + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
		mq_sat_d = 1'b0;
		if (!pneg && prnd > 64'h7fffffff) begin
			mq_d = Q_MAX;
			mq_sat_d = 1'b1;
		end else if (pneg && prnd > 64'h80000000) begin
			mq_d = Q_MIN;
			mq_sat_d = 1'b1;
		end else if (pneg) begin
			mq_d = -q_t'(prnd[31:0]);
		end else begin
			mq_d = q_t'(prnd[31:0]);
		end
	end

	always_comb begin
		sum = cmd.mac_sub ? 33'(addend) - 33'(mq_q) : 33'(addend) + 33'(mq_q);
		add_sat = sum[32] != sum[31];
		if (add_sat) begin
			mac_res = sum[32] ? Q_MIN : Q_MAX;
		end else begin
			mac_res = q_t'(sum[31:0]);
		end
	end

	assign dif_wd = (cmd.dif_wsel == DWS_DIV) ? div_quot : in_f;

	always_comb begin
		case (cmd.bas_wsel)
			BWS_ONE: bas_wd = Q_ONE;
			BWS_MAC: bas_wd = mac_res;
			default: bas_wd = '0;
		endcase
		case (cmd.cof_wsel)
			CWS_COPY: cof_wd = dif_a;
			CWS_MAC: cof_wd = mac_res;
			default: cof_wd = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.x_load) begin
			x_q <= in_x;
		end
		if (cmd.acc_load_coef) begin
			acc_q <= cof_a;
		end else if (cmd.acc_load_mac) begin
			acc_q <= mac_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sat_q <= 1'b0;
		end else if (cmd.sat_clr) begin
			sat_q <= 1'b0;
		end else if (cmd.mac_commit) begin
			sat_q <= sat_q | mq_sat_q | add_sat;
		end else if (cmd.div_commit) begin
			sat_q <= sat_q | div_sat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_kind <= cmd.out_kind;
			out_power <= cmd.out_power;
			out_last <= cmd.out_last;
			out_status <= cmd.out_status;
			case (cmd.out_vsel)
				OUT_ACC: out_value <= acc_q;
				OUT_COEF: out_value <= cof_b;
				default: out_value <= '0;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign sts.den_zero = den == '0;
	assign sts.div_done = div_done;
	assign sts.out_free = !out_valid_q || out_ready;
	assign sts.sat = sat_q;

endmodule

// ===== rtl/npf_ctrl.sv =====
`timescale 1ns / 1ps
module npf_ctrl import npf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic in_mode,
	input  logic in_last,
	input  sts_t sts,
	output cmd_t cmd
);

	localparam logic [4:0] S_IDLE = 5'd0;
	localparam logic [4:0] S_ERR = 5'd1;
	localparam logic [4:0] S_EV_LD = 5'd2;
	localparam logic [4:0] S_EV_LD2 = 5'd3;
	localparam logic [4:0] S_EV_MUL = 5'd4;
	localparam logic [4:0] S_EV_RND = 5'd5;
	localparam logic [4:0] S_EV_ADD = 5'd6;
	localparam logic [4:0] S_EV_OUT = 5'd7;
	localparam logic [4:0] S_D_RD = 5'd8;
	localparam logic [4:0] S_D_SUB = 5'd9;
	localparam logic [4:0] S_D_RUN = 5'd10;
	localparam logic [4:0] S_D_WR = 5'd11;
	localparam logic [4:0] S_C_CLR = 5'd12;
	localparam logic [4:0] S_C_C0 = 5'd13;
	localparam logic [4:0] S_B_RD = 5'd14;
	localparam logic [4:0] S_B_MUL = 5'd15;
	localparam logic [4:0] S_B_RND = 5'd16;
	localparam logic [4:0] S_B_WR = 5'd17;
	localparam logic [4:0] S_K_RD = 5'd18;
	localparam logic [4:0] S_K_MUL = 5'd19;
	localparam logic [4:0] S_K_RND = 5'd20;
	localparam logic [4:0] S_K_WR = 5'd21;
	localparam logic [4:0] S_E_RD = 5'd22;
	localparam logic [4:0] S_E_OUT = 5'd23;

	logic [4:0] state_q, state_d;
	cnt_t pc_q, pc_d, n_q, n_d, i_q, i_d, j_q, j_d, k_q, k_d, cc_q, cc_d;
	logic fit_valid_q, fit_valid_d, ovf_q, ovf_d, ekind_q, ekind_d;
	logic [STATUS_W-1:0] estat_q, estat_d;
	cnt_t jm1, jmi, im1, n_new;
	logic ovf;

	assign jm1 = j_q - 1'b1;
	assign jmi = j_q - i_q;
	assign im1 = i_q - 1'b1;
	assign ovf = pc_q >= cnt_t'(MAX_POINTS);
	assign n_new = ovf ? pc_q : pc_q + 1'b1;

	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		state_d = state_q;
		pc_d = pc_q;
		n_d = n_q;
		i_d = i_q;
		j_d = j_q;
		k_d = k_q;
		cc_d = cc_q;
		fit_valid_d = fit_valid_q;
		ovf_d = ovf_q;
		ekind_d = ekind_q;
		estat_d = estat_q;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				cmd.wa = pc_q[AW-1:0];
				if (in_valid) begin
					cmd.x_load = 1'b1;
					if (in_mode == MODE_EVAL) begin
						if (!fit_valid_q || cc_q == '0) begin
							ekind_d = KIND_VALUE;
							estat_d = ST_NOFIT;
							state_d = S_ERR;
						end else begin
							i_d = cc_q - 1'b1;
							cmd.sat_clr = 1'b1;
							state_d = S_EV_LD;
						end
					end else begin
						cmd.abs_we = !ovf;
						cmd.dif_we = !ovf;
						cmd.dif_wsel = DWS_IN;
						if (!in_last) begin
							if (ovf) begin
								ekind_d = KIND_COEF;
								estat_d = ST_FULL;
								state_d = S_ERR;
							end else begin
								pc_d = n_new;
							end
						end else begin
							pc_d = '0;
							n_d = n_new;
							ovf_d = ovf;
							cmd.sat_clr = 1'b1;
							if (n_new == cnt_t'(1)) begin
								j_d = '0;
								state_d = S_C_CLR;
							end else begin
								i_d = cnt_t'(1);
								j_d = n_new - 1'b1;
								state_d = S_D_RD;
							end
						end
					end
				end
			end
			S_ERR: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_vsel = OUT_ZERO;
					cmd.out_kind = ekind_q;
					cmd.out_last = 1'b1;
					cmd.out_status = estat_q;
					state_d = S_IDLE;
				end
			end
			S_EV_LD: begin
				cmd.cof_ra = i_q[AW-1:0];
				state_d = S_EV_LD2;
			end
			S_EV_LD2: begin
				cmd.cof_ra = i_q[AW-1:0];
				cmd.acc_load_coef = 1'b1;
				state_d = (i_q == '0) ? S_EV_OUT : S_EV_MUL;
			end
			S_EV_MUL, S_EV_RND, S_EV_ADD: begin
				cmd.cof_ra = im1[AW-1:0];
				cmd.opa_sel = OPA_X;
				cmd.opb_sel = OPB_ACC;
				cmd.add_sel = ADD_COF;
				if (state_q == S_EV_MUL) begin
					state_d = S_EV_RND;
				end else if (state_q == S_EV_RND) begin
					state_d = S_EV_ADD;
				end else begin
					cmd.acc_load_mac = 1'b1;
					cmd.mac_commit = 1'b1;
					i_d = im1;
					state_d = (i_q == cnt_t'(1)) ? S_EV_OUT : S_EV_MUL;
				end
			end
			S_EV_OUT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_vsel = OUT_ACC;
					cmd.out_kind = KIND_VALUE;
					cmd.out_last = 1'b1;
					cmd.out_status = sts.sat ? ST_SAT : ST_OK;
					state_d = S_IDLE;
				end
			end
			S_D_RD, S_D_SUB, S_D_RUN, S_D_WR: begin
				cmd.abs_ra = j_q[AW-1:0];
				cmd.abs_rb = jmi[AW-1:0];
				cmd.dif_ra = j_q[AW-1:0];
				cmd.dif_rb = jm1[AW-1:0];
				cmd.wa = j_q[AW-1:0];
				case (state_q)
					S_D_RD: state_d = S_D_SUB;
					S_D_SUB: begin
						if (sts.den_zero) begin
							fit_valid_d = 1'b0;
							cc_d = '0;
							ekind_d = KIND_COEF;
							estat_d = ST_EQUAL;
							state_d = S_ERR;
						end else begin
							cmd.div_start = 1'b1;
							state_d = S_D_RUN;
						end
					end
					S_D_RUN: begin
						if (sts.div_done) begin
							state_d = S_D_WR;
						end
					end
					default: begin
						cmd.dif_we = 1'b1;
						cmd.dif_wsel = DWS_DIV;
						cmd.div_commit = 1'b1;
						if (j_q == i_q) begin
							if (i_q + 1'b1 == n_q) begin
								j_d = '0;
								state_d = S_C_CLR;
							end else begin
								i_d = i_q + 1'b1;
								j_d = n_q - 1'b1;
								state_d = S_D_RD;
							end
						end else begin
							j_d = jm1;
							state_d = S_D_RD;
						end
					end
				endcase
			end
			S_C_CLR: begin
				cmd.wa = j_q[AW-1:0];
				cmd.bas_we = 1'b1;
				cmd.bas_wsel = (j_q == '0) ? BWS_ONE : BWS_ZERO;
				cmd.cof_we = 1'b1;
				cmd.cof_wsel = CWS_ZERO;
				if (j_q == n_q - 1'b1) begin
					state_d = S_C_C0;
				end else begin
					j_d = j_q + 1'b1;
				end
			end
			S_C_C0: begin
				cmd.cof_we = 1'b1;
				cmd.cof_wsel = CWS_COPY;
				if (n_q == cnt_t'(1)) begin
					fit_valid_d = 1'b1;
					cc_d = n_q;
					k_d = '0;
					state_d = S_E_RD;
				end else begin
					i_d = cnt_t'(1);
					j_d = cnt_t'(1);
					state_d = S_B_RD;
				end
			end
			S_B_RD, S_B_MUL, S_B_RND, S_B_WR: begin
				cmd.abs_ra = im1[AW-1:0];
				cmd.bas_ra = j_q[AW-1:0];
				cmd.bas_rb = jm1[AW-1:0];
				cmd.wa = j_q[AW-1:0];
				cmd.opa_sel = OPA_ABS;
				cmd.opb_sel = OPB_BAS;
				cmd.add_sel = (j_q == '0) ? ADD_ZERO : ADD_BAS;
				cmd.mac_sub = 1'b1;
				case (state_q)
					S_B_RD: state_d = S_B_MUL;
					S_B_MUL: state_d = S_B_RND;
					S_B_RND: state_d = S_B_WR;
					default: begin
						cmd.bas_we = 1'b1;
						cmd.bas_wsel = BWS_MAC;
						cmd.mac_commit = 1'b1;
						if (j_q == '0) begin
							state_d = S_K_RD;
						end else begin
							j_d = jm1;
							state_d = S_B_RD;
						end
					end
				endcase
			end
			S_K_RD, S_K_MUL, S_K_RND, S_K_WR: begin
				cmd.dif_ra = i_q[AW-1:0];
				cmd.bas_ra = j_q[AW-1:0];
				cmd.cof_ra = j_q[AW-1:0];
				cmd.wa = j_q[AW-1:0];
				cmd.opa_sel = OPA_DIF;
				cmd.opb_sel = OPB_BAS;
				cmd.add_sel = ADD_COF;
				case (state_q)
					S_K_RD: state_d = S_K_MUL;
					S_K_MUL: state_d = S_K_RND;
					S_K_RND: state_d = S_K_WR;
					default: begin
						cmd.cof_we = 1'b1;
						cmd.cof_wsel = CWS_MAC;
						cmd.mac_commit = 1'b1;
						if (j_q == i_q) begin
							if (i_q == n_q - 1'b1) begin
								fit_valid_d = 1'b1;
								cc_d = n_q;
								k_d = '0;
								state_d = S_E_RD;
							end else begin
								i_d = i_q + 1'b1;
								j_d = i_q + 1'b1;
								state_d = S_B_RD;
							end
						end else begin
							j_d = j_q + 1'b1;
							state_d = S_K_RD;
						end
					end
				endcase
			end
			S_E_RD: begin
				cmd.cof_rb = k_q[AW-1:0];
				state_d = S_E_OUT;
			end
			S_E_OUT: begin
				cmd.cof_rb = k_q[AW-1:0];
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_vsel = OUT_COEF;
					cmd.out_kind = KIND_COEF;
					cmd.out_power = POWER_W'(k_q);
					cmd.out_last = k_q == n_q - 1'b1;
					cmd.out_status = sts.sat ? ST_SAT : (ovf_q ? ST_FULL : ST_OK);
					if (k_q == n_q - 1'b1) begin
						state_d = S_IDLE;
					end else begin
						k_d = k_q + 1'b1;
						state_d = S_E_RD;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pc_q <= '0;
			n_q <= '0;
			i_q <= '0;
			j_q <= '0;
			k_q <= '0;
			cc_q <= '0;
			fit_valid_q <= 1'b0;
			ovf_q <= 1'b0;
			ekind_q <= KIND_COEF;
			estat_q <= ST_OK;
		end else begin
			state_q <= state_d;
			pc_q <= pc_d;
			n_q <= n_d;
			i_q <= i_d;
			j_q <= j_d;
			k_q <= k_d;
			cc_q <= cc_d;
			fit_valid_q <= fit_valid_d;
			ovf_q <= ovf_d;
			ekind_q <= ekind_d;
			estat_q <= estat_d;
		end
	end

endmodule

// ===== rtl/newton_poly_fit_eval.sv =====
// Newton divided-difference polynomial fit and evaluator, signed Q16.16.
// The input stream carries one point or query per transfer: tuser selects
// load (0) or evaluate (1), tlast marks the final point of a set. Loaded
// points are stored; the final point starts the fit, which returns one
// coefficient transfer per point, lowest power first, tlast on the highest.
// An evaluation returns a single transfer with tuser high and tlast high.
// A fit with two equal x values returns one error transfer, no coefficients.
// A load point without tlast returns nothing unless the point set is full,
// when it returns a single error transfer. An evaluation runs on the shared
// multiply, round and accumulate unit. A fit computes the divided differences,
// each running through the bit-serial divider (49 steps), then the basis and
// coefficient updates on the same multiply unit, then emits the coefficients.
// The input is ready only while the controller is idle; the output register
// lets the next item be taken while the last result still waits.
// If the receiver stalls, the block holds its result and waits.
// Reset empties the point set, clears the fit and drops any pending result.
`timescale 1ns / 1ps
module newton_poly_fit_eval import npf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,  // x_value[31:0], f_value[63:32]
	input  logic        s_tuser,  // mode
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,  // value[31:0], power_index[35:32], status[38:36], zero[39]
	output logic        m_tuser,  // result_kind
	output logic        m_tlast
);

	cmd_t cmd;
	sts_t sts;
	q_t out_value;
	logic [POWER_W-1:0] out_power;
	logic [STATUS_W-1:0] out_status;

	npf_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.in_mode(s_tuser),
		.in_last(s_tlast),
		.sts(sts),
		.cmd(cmd)
	);

	npf_datapath u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.sts(sts),
		.in_x(q_t'(s_tdata[31:0])),
		.in_f(q_t'(s_tdata[63:32])),
		.out_ready(m_tready),
		.out_valid(m_tvalid),
		.out_kind(m_tuser),
		.out_value(out_value),
		.out_power(out_power),
		.out_last(m_tlast),
		.out_status(out_status)
	);

	assign m_tdata = {1'b0, out_status, out_power, out_value};

endmodule

// ===== rtl/npf_checker.sv =====
`timescale 1ns / 1ps
module npf_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata,
	input logic        m_tuser,
	input logic        m_tlast
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("result changed while stalled");

	a_value_single: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast && m_tdata[35:32] == 4'd0)
		else $error("evaluated value not a single result");

	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[38:36] == 3'd1 || m_tdata[38:36] == 3'd4)
		|-> m_tlast && m_tdata[31:0] == 32'd0)
		else $error("error result carries data");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[38:36] <= 3'd4 && !m_tdata[39])
		else $error("status code out of range");

endmodule

bind newton_poly_fit_eval npf_checker u_npf_checker (.*);
